>>> sv/lasb_pkg.sv
// Shared types, codes and the helper function of the shard balancer.
package lasb_pkg;

  localparam int CMD_W     = 2;
  localparam int IDX_W     = 6;
  localparam int PATH_W    = 2;
  localparam int CNT_W     = 7;
  localparam int THR_W     = 8;
  localparam int SEED_W    = 64;
  localparam int CFG_IDX_W = 2;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [PATH_W-1:0]    path_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [SEED_W-1:0]    seed_t;

  localparam cmd_t CMD_ROUTE   = 2'd0;
  localparam cmd_t CMD_INSERT  = 2'd1;
  localparam cmd_t CMD_REMOVE  = 2'd2;
  localparam cmd_t CMD_INVALID = 2'd3;

  localparam path_t PATH_NATURAL = 2'd0;
  localparam path_t PATH_LEAST   = 2'd1;
  localparam path_t PATH_RANDOM  = 2'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  localparam cfg_idx_t CFG_SHARD_COUNT = 2'd0;
  localparam cfg_idx_t CFG_THRESHOLD   = 2'd1;
  localparam cfg_idx_t CFG_SEED        = 2'd2;

  localparam logic [CNT_W-1:0] CNT_RESET  = 7'd64;
  localparam logic [THR_W-1:0] THR_RESET  = 8'd24;
  localparam seed_t            SEED_RESET = 64'd16045690984503098046;

  function automatic seed_t xs64(input seed_t x);
    seed_t a;
    seed_t b;
    a = x ^ (x << 13);
    b = a ^ (a >> 7);
    return b ^ (b << 17);
  endfunction

endpackage

>>> sv/lasb_in_if.sv
// Input item channel of the shard balancer.
interface lasb_in_if;
  logic            valid;
  logic            ready;
  lasb_pkg::cmd_t  command;
  lasb_pkg::idx_t  shard_index;

  modport source (output valid, output command, output shard_index, input ready);
  modport sink (input valid, input command, input shard_index, output ready);
endinterface

>>> sv/lasb_out_if.sv
// Result item channel of the shard balancer.
interface lasb_out_if;
  logic            valid;
  logic            ready;
  lasb_pkg::idx_t  chosen_shard;
  lasb_pkg::path_t route_path;
  logic            status;

  modport source (output valid, output chosen_shard, output route_path, output status,
                  input ready);
  modport sink (input valid, input chosen_shard, input route_path, input status,
                output ready);
endinterface

>>> sv/lasb_cfg_if.sv
// Configuration write channel of the shard balancer.
interface lasb_cfg_if;
  logic               valid;
  logic               ready;
  lasb_pkg::cfg_idx_t index;
  lasb_pkg::seed_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/lasb_ram.sv
// Generic simple dual-port RAM with registered read data.
module lasb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/load_aware_shard_balancer_core.sv
// Load-aware shard balancer: per-shard load counters in RAM, routing by scan.
// Ignored items go straight to the result; insert/remove reads a load and writes it back;
// a route scans n active shards, one RAM read each; random picks use a bit-serial modulo.
// Next item accepted in the cycle after its result is registered; a held result stalls input.
// Reset: a clearing pass writes zero to all MAX_SHARDS loads, one per cycle, with no
// item accepted meanwhile; state, count, threshold, output valid and generator are reset.
module load_aware_shard_balancer_core #(
  parameter int MAX_SHARDS = 64,
  parameter int LOAD_WIDTH = 32
) (
  input logic         clk,
  input logic         rst_n,
  lasb_in_if.sink     in_ch,
  lasb_out_if.source  out_ch,
  lasb_cfg_if.sink    cfg_ch
);

  localparam int AW  = $clog2(MAX_SHARDS);
  localparam int CW  = ($clog2(MAX_SHARDS + 1) > lasb_pkg::CNT_W) ?
                       $clog2(MAX_SHARDS + 1) : lasb_pkg::CNT_W;
  localparam int LW  = LOAD_WIDTH;
  localparam int TW  = LW + CW;
  localparam int MW  = LW + CW;
  localparam int PW  = TW + lasb_pkg::THR_W;
  localparam int SW  = lasb_pkg::SEED_W;
  localparam int BW  = $clog2(SW);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_MOD   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]                      state_r, state_nxt;
  logic [AW-1:0]                   clr_r, clr_nxt;
  logic [lasb_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [lasb_pkg::THR_W-1:0]      thr_r, thr_nxt;
  lasb_pkg::seed_t                 gen_r, gen_nxt;
  logic                            out_valid_r, out_valid_nxt;

  lasb_pkg::cmd_t                  cmd_r, cmd_nxt;
  lasb_pkg::idx_t                  idx_r, idx_nxt;
  logic [CW-1:0]                   dat_r, dat_nxt;
  logic [TW-1:0]                   sum_r, sum_nxt;
  logic [LW-1:0]                   min_r, min_nxt;
  logic [CW-1:0]                   best_r, best_nxt;
  logic [LW-1:0]                   nat_r, nat_nxt;
  logic [MW-1:0]                   pa_r, pa_nxt;
  logic [PW-1:0]                   pb_r, pb_nxt;
  logic [MW-1:0]                   pc_r, pc_nxt;
  lasb_pkg::seed_t                 div_r, div_nxt;
  logic [CW-1:0]                   rem_r, rem_nxt;
  logic [BW-1:0]                   bit_r, bit_nxt;
  lasb_pkg::idx_t                  res_shard_r, res_shard_nxt;
  lasb_pkg::path_t                 res_path_r, res_path_nxt;
  logic                            res_status_r, res_status_nxt;
  lasb_pkg::idx_t                  out_shard_r, out_shard_nxt;
  lasb_pkg::path_t                 out_path_r, out_path_nxt;
  logic                            out_status_r, out_status_nxt;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [LW-1:0]                   ram_wdata;
  logic [AW-1:0]                   ram_raddr;
  logic [LW-1:0]                   ram_rdata;

  logic [CW-1:0]                   n_act;
  logic [LW-1:0]                   upd_val;
  logic [CW:0]                     mod_t;
  logic [CW-1:0]                   mod_rem;

  lasb_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_SHARDS)
  ) u_load_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign n_act = (cnt_r == '0) ? CW'(1) :
                 ((CW'(cnt_r) > CW'(MAX_SHARDS)) ? CW'(MAX_SHARDS) : CW'(cnt_r));

  always_comb begin
    case (cmd_r)
      lasb_pkg::CMD_INSERT: upd_val = (ram_rdata != '1) ? ram_rdata + LW'(1) : ram_rdata;
      lasb_pkg::CMD_REMOVE: upd_val = (ram_rdata != '0) ? ram_rdata - LW'(1) : ram_rdata;
      default:              upd_val = ram_rdata;
    endcase
  end

  assign mod_t   = {rem_r, div_r[SW-1]};
  assign mod_rem = (mod_t >= {1'b0, n_act}) ? CW'(mod_t - {1'b0, n_act}) : CW'(mod_t);

  assign in_ch.ready         = (state_r == S_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.chosen_shard = out_shard_r;
  assign out_ch.route_path   = out_path_r;
  assign out_ch.status       = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cnt_nxt        = cnt_r;
    thr_nxt        = thr_r;
    gen_nxt        = gen_r;
    out_valid_nxt  = out_valid_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    dat_nxt        = dat_r;
    sum_nxt        = sum_r;
    min_nxt        = min_r;
    best_nxt       = best_r;
    nat_nxt        = nat_r;
    pa_nxt         = pa_r;
    pb_nxt         = pb_r;
    pc_nxt         = pc_r;
    div_nxt        = div_r;
    rem_nxt        = rem_r;
    bit_nxt        = bit_r;
    res_shard_nxt  = res_shard_r;
    res_path_nxt   = res_path_r;
    res_status_nxt = res_status_r;
    out_shard_nxt  = out_shard_r;
    out_path_nxt   = out_path_r;
    out_status_nxt = out_status_r;

    ram_we    = 1'b0;
    ram_waddr = AW'(idx_r);
    ram_wdata = upd_val;
    ram_raddr = AW'(dat_r + CW'(1));

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(MAX_SHARDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_raddr = (in_ch.command == lasb_pkg::CMD_ROUTE) ? '0 : AW'(in_ch.shard_index);
        if (in_ch.valid) begin
          cmd_nxt        = in_ch.command;
          idx_nxt        = in_ch.shard_index;
          dat_nxt        = '0;
          sum_nxt        = '0;
          min_nxt        = '1;
          best_nxt       = '0;
          res_shard_nxt  = in_ch.shard_index;
          res_path_nxt   = lasb_pkg::PATH_NATURAL;
          res_status_nxt = lasb_pkg::STATUS_OK;
          if (in_ch.command == lasb_pkg::CMD_INVALID || CW'(in_ch.shard_index) >= n_act) begin
            res_status_nxt = lasb_pkg::STATUS_IGNORED;
            state_nxt      = S_DONE;
          end else if (in_ch.command == lasb_pkg::CMD_ROUTE) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_UPD;
          end
        end
      end
      S_UPD: begin
        ram_we    = 1'b1;
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        sum_nxt = sum_r + TW'(ram_rdata);
        if (ram_rdata < min_r) begin
          min_nxt  = ram_rdata;
          best_nxt = dat_r;
        end
        if (dat_r == CW'(idx_r)) begin
          nat_nxt = ram_rdata;
        end
        dat_nxt = dat_r + CW'(1);
        if (dat_r == n_act - CW'(1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        pa_nxt    = MW'(nat_r) * MW'(n_act);
        pb_nxt    = PW'(thr_r) * PW'(sum_r);
        pc_nxt    = MW'(min_r) * MW'(n_act);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (PW'({pa_r, 4'b0000}) <= pb_r) begin
          state_nxt = S_DONE;
        end else if (PW'(pc_r) < PW'(sum_r)) begin
          res_shard_nxt = best_r[lasb_pkg::IDX_W-1:0];
          res_path_nxt  = lasb_pkg::PATH_LEAST;
          state_nxt     = S_DONE;
        end else begin
          gen_nxt   = lasb_pkg::xs64(gen_r);
          div_nxt   = lasb_pkg::xs64(gen_r);
          rem_nxt   = '0;
          bit_nxt   = BW'(SW - 1);
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        rem_nxt = mod_rem;
        div_nxt = div_r << 1;
        bit_nxt = bit_r - BW'(1);
        if (bit_r == '0) begin
          res_shard_nxt = mod_rem[lasb_pkg::IDX_W-1:0];
          res_path_nxt  = lasb_pkg::PATH_RANDOM;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_shard_nxt  = res_shard_r;
          out_path_nxt   = res_path_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        lasb_pkg::CFG_SHARD_COUNT: cnt_nxt = cfg_ch.data[lasb_pkg::CNT_W-1:0];
        lasb_pkg::CFG_THRESHOLD:   thr_nxt = cfg_ch.data[lasb_pkg::THR_W-1:0];
        lasb_pkg::CFG_SEED:        gen_nxt = cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= lasb_pkg::CNT_RESET;
      thr_r       <= lasb_pkg::THR_RESET;
      gen_r       <= lasb_pkg::SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      thr_r       <= thr_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    dat_r        <= dat_nxt;
    sum_r        <= sum_nxt;
    min_r        <= min_nxt;
    best_r       <= best_nxt;
    nat_r        <= nat_nxt;
    pa_r         <= pa_nxt;
    pb_r         <= pb_nxt;
    pc_r         <= pc_nxt;
    div_r        <= div_nxt;
    rem_r        <= rem_nxt;
    bit_r        <= bit_nxt;
    res_shard_r  <= res_shard_nxt;
    res_path_r   <= res_path_nxt;
    res_status_r <= res_status_nxt;
    out_shard_r  <= out_shard_nxt;
    out_path_r   <= out_path_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule
